// ----- src/ifsf_pkg.sv -----
// ----------------------------------------------------------------------------
// ifsf_pkg
// Types, codes and helpers shared by the integer format-spec formatter.
// ----------------------------------------------------------------------------
package ifsf_pkg;

  localparam int unsigned MAX_CHARS_DEF = 64;

  // Digit shift register: 20 BCD digits, or the value left aligned.
  localparam int unsigned DIG_W      = 80;
  localparam int unsigned BCD_DIGITS = 20;

  // Configuration register indexes
  localparam logic [2:0] REG_FILL  = 3'd0;
  localparam logic [2:0] REG_ALIGN = 3'd1;
  localparam logic [2:0] REG_SIGN  = 3'd2;
  localparam logic [2:0] REG_ALT   = 3'd3;
  localparam logic [2:0] REG_ZERO  = 3'd4;
  localparam logic [2:0] REG_WIDTH = 3'd5;
  localparam logic [2:0] REG_TYPE  = 3'd6;
  localparam logic [2:0] REG_LIMIT = 3'd7;

  // Type codes
  localparam logic [2:0] TYPE_D  = 3'd0;
  localparam logic [2:0] TYPE_X  = 3'd1;
  localparam logic [2:0] TYPE_XU = 3'd2;
  localparam logic [2:0] TYPE_O  = 3'd3;
  localparam logic [2:0] TYPE_B  = 3'd4;
  localparam logic [2:0] TYPE_N  = 3'd5;

  // Align codes
  localparam logic [2:0] AL_NONE   = 3'd0;
  localparam logic [2:0] AL_LEFT   = 3'd1;
  localparam logic [2:0] AL_RIGHT  = 3'd2;
  localparam logic [2:0] AL_CENTRE = 3'd3;
  localparam logic [2:0] AL_SIGNED = 3'd4;

  // Sign codes
  localparam logic [1:0] SG_MINUS = 2'd0;
  localparam logic [1:0] SG_PLUS  = 2'd1;
  localparam logic [1:0] SG_SPACE = 2'd2;

  // Characters
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LO    = 8'h6f;
  localparam logic [7:0] CH_LB    = 8'h62;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_LA    = 8'h61;

  typedef enum logic [1:0] {
    DK_BIN,
    DK_OCT,
    DK_HEX
  } dig_kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CONV,
    ST_NORM,
    ST_SETUP,
    ST_LPAD,
    ST_SIGN,
    ST_MPAD,
    ST_PFX0,
    ST_PFX1,
    ST_DIG,
    ST_RPAD
  } state_e;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] base;
    base = upper ? CH_UA : CH_LA;
    if (d < 4'd10) begin
      digit_char = CH_ZERO + {4'b0, d};
    end else begin
      digit_char = base + {4'b0, d} - 8'd10;
    end
  endfunction

endpackage

// ----- src/integer_format_spec_formatter.sv -----
// ----------------------------------------------------------------------------
// integer_format_spec_formatter
// Formats a 64-bit integer (signed in the decimal modes) as padded text.
// ----------------------------------------------------------------------------
// Usage:
//   Configure the spec through cfg_we_i / cfg_idx_i / cfg_data_i while busy_o
//   is low. A request is taken when start_i is high and busy_o is low.
//   Each character appears on out_char_o for one cycle with out_strobe_o high;
//   last_char_o marks the final character. The receiver cannot stall.
// Operation:
//   Decimal modes run a shift-and-add-3 binary to BCD conversion. Then
//   leading zero digits are dropped one at a time (up to 19 decimal, 63
//   binary) until the first nonzero digit is found, and a setup step
//   follows. Characters then go out one per cycle, with a state also spent
//   on each empty pad, sign or prefix segment ahead of the last character.
//   Each character shows in the cycle after the state that selects it
//   because the output is registered; busy_o drops with the last character.
// Reset:
//   Configuration returns to fill ' ', no alignment, minus-only sign, no
//   prefix, no zero pad, width 0, plain decimal, limit 64. No request is
//   in flight after reset.
// ----------------------------------------------------------------------------
module integer_format_spec_formatter
  import ifsf_pkg::*;
#(
  parameter int unsigned MaxChars = MAX_CHARS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [63:0] value_i,
  output logic        out_strobe_o,
  output logic [7:0]  out_char_o,
  output logic        last_char_o
);

  // Configuration
  logic [7:0] fill_char_q;
  logic [2:0] align_q;
  logic [1:0] sign_mode_q;
  logic       alt_q;
  logic       zero_pad_q;
  logic [6:0] min_width_q;
  logic [2:0] type_q;
  logic [6:0] limit_q;

  state_e state_q, state_d;

  logic [63:0]      val_q, val_d;
  logic [DIG_W-1:0] dig_q, dig_d;
  logic [5:0]       step_q, step_d;
  logic [6:0]       ndig_q, ndig_d;
  dig_kind_e        kind_q, kind_d;
  logic             sign_q, sign_d;
  logic [7:0]       sign_ch_q, sign_ch_d;
  logic             pfx_q, pfx_d;
  logic [7:0]       pfx_ch_q, pfx_ch_d;
  logic             upper_q, upper_d;
  logic [7:0]       fill_q, fill_d;
  logic [6:0]       lpad_q, lpad_d, mpad_q, mpad_d, rpad_q, rpad_d;
  logic [6:0]       total_q, total_d, ocnt_q, ocnt_d;
  logic             strobe_q, strobe_d, last_q, last_d;
  logic [7:0]       char_q, char_d;

  // Decoded spec
  logic [2:0] type_eff;
  logic       is_dec;
  logic       neg;
  logic [3:0] top_dig;
  logic       emit, emit_last;
  logic [7:0] emit_ch;

  // Setup values
  logic [6:0] slen, pad, full_len, cap, total_c;
  logic [6:0] lpad_c, mpad_c, rpad_c;
  logic [2:0] al_raw, al_eff;
  logic [7:0] fill_c;

  always_comb begin
    type_eff = (type_q > TYPE_N) ? TYPE_N : type_q;
    is_dec   = (type_eff == TYPE_D) || (type_eff == TYPE_N);
    neg      = value_i[63];
    case (kind_q)
      DK_BIN:  top_dig = {3'b0, dig_q[DIG_W-1]};
      DK_OCT:  top_dig = {1'b0, dig_q[DIG_W-1 -: 3]};
      default: top_dig = dig_q[DIG_W-1 -: 4];
    endcase
  end

  // Field layout, padding split and truncation
  always_comb begin
    slen     = ndig_q + {6'b0, sign_q} + (pfx_q ? 7'd2 : 7'd0);
    pad      = (min_width_q > slen) ? (min_width_q - slen) : 7'd0;
    full_len = slen + pad;
    cap      = (limit_q > 7'(MaxChars)) ? 7'(MaxChars) : limit_q;
    total_c  = (full_len < cap) ? full_len : cap;
    al_raw   = (align_q > AL_SIGNED) ? AL_NONE : align_q;
    fill_c   = (zero_pad_q && (al_raw == AL_NONE)) ? CH_ZERO : fill_char_q;
    if (al_raw == AL_NONE) begin
      al_eff = zero_pad_q ? AL_RIGHT : AL_LEFT;
    end else begin
      al_eff = al_raw;
    end
    lpad_c = 7'd0;
    mpad_c = 7'd0;
    rpad_c = 7'd0;
    // Sign goes ahead of the padding for '=' or zero fill on the right.
    if (sign_q && (((al_eff == AL_RIGHT) && (fill_c == CH_ZERO)) ||
                   (al_eff == AL_SIGNED))) begin
      mpad_c = pad;
    end else if (al_eff == AL_LEFT) begin
      rpad_c = pad;
    end else if (al_eff == AL_CENTRE) begin
      lpad_c = pad >> 1;
      rpad_c = pad - (pad >> 1);
    end else begin
      lpad_c = pad;
    end
  end

  // Character selection for the current segment
  always_comb begin
    emit    = 1'b0;
    emit_ch = fill_q;
    case (state_q)
      ST_LPAD: emit = (lpad_q != 7'd0);
      ST_SIGN: begin
        emit    = sign_q;
        emit_ch = sign_ch_q;
      end
      ST_MPAD: emit = (mpad_q != 7'd0);
      ST_PFX0: begin
        emit    = pfx_q;
        emit_ch = CH_ZERO;
      end
      ST_PFX1: begin
        emit    = pfx_q;
        emit_ch = pfx_ch_q;
      end
      ST_DIG: begin
        emit    = 1'b1;
        emit_ch = digit_char(top_dig, upper_q);
      end
      ST_RPAD: emit = (rpad_q != 7'd0);
      default: emit = 1'b0;
    endcase
    emit_last = emit && ((ocnt_q + 7'd1) == total_q);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = is_dec ? ST_CONV : ST_NORM;
      end
      ST_CONV: begin
        if (step_q == 6'h3f) state_d = ST_NORM;
      end
      ST_NORM: begin
        if (!((ndig_q > 7'd1) && (top_dig == 4'd0))) state_d = ST_SETUP;
      end
      ST_SETUP: state_d = (total_c == 7'd0) ? ST_IDLE : ST_LPAD;
      ST_LPAD:  state_d = emit_last ? ST_IDLE : (lpad_q <= 7'd1) ? ST_SIGN : ST_LPAD;
      ST_SIGN:  state_d = emit_last ? ST_IDLE : ST_MPAD;
      ST_MPAD:  state_d = emit_last ? ST_IDLE : (mpad_q <= 7'd1) ? ST_PFX0 : ST_MPAD;
      ST_PFX0:  state_d = emit_last ? ST_IDLE : pfx_q ? ST_PFX1 : ST_DIG;
      ST_PFX1:  state_d = emit_last ? ST_IDLE : ST_DIG;
      ST_DIG:   state_d = emit_last ? ST_IDLE : (ndig_q == 7'd1) ? ST_RPAD : ST_DIG;
      ST_RPAD:  state_d = (emit_last || (rpad_q <= 7'd1)) ? ST_IDLE : ST_RPAD;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    logic [DIG_W-1:0] bcd_adj;
    logic [3:0]       bd;
    logic [63:0]      mag;

    val_d     = val_q;
    dig_d     = dig_q;
    step_d    = step_q;
    ndig_d    = ndig_q;
    kind_d    = kind_q;
    sign_d    = sign_q;
    sign_ch_d = sign_ch_q;
    pfx_d     = pfx_q;
    pfx_ch_d  = pfx_ch_q;
    upper_d   = upper_q;
    fill_d    = fill_q;
    lpad_d    = lpad_q;
    mpad_d    = mpad_q;
    rpad_d    = rpad_q;
    total_d   = total_q;
    ocnt_d    = ocnt_q;
    strobe_d  = emit;
    last_d    = emit_last;
    char_d    = emit_ch;

    mag = neg ? (~value_i + 64'd1) : value_i;

    // add-3 correction on every BCD digit, one shared step per cycle
    for (int k = 0; k < BCD_DIGITS; k++) begin
      bd = dig_q[4*k +: 4];
      bcd_adj[4*k +: 4] = (bd >= 4'd5) ? (bd + 4'd3) : bd;
    end

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          step_d   = 6'd0;
          upper_d  = (type_eff == TYPE_XU);
          sign_d   = 1'b0;
          sign_ch_d = CH_MINUS;
          pfx_d    = 1'b0;
          pfx_ch_d = CH_LX;
          if (is_dec) begin
            val_d  = mag;
            dig_d  = '0;
            ndig_d = 7'(BCD_DIGITS);
            kind_d = DK_HEX;
            if (neg) begin
              sign_d = 1'b1;
            end else if ((type_eff == TYPE_D) && (sign_mode_q == SG_PLUS)) begin
              sign_d    = 1'b1;
              sign_ch_d = CH_PLUS;
            end else if ((type_eff == TYPE_D) && (sign_mode_q == SG_SPACE)) begin
              sign_d    = 1'b1;
              sign_ch_d = CH_SPACE;
            end
          end else begin
            pfx_d = alt_q;
            case (type_eff)
              TYPE_O: begin
                dig_d    = {2'b0, value_i, 14'b0};
                ndig_d   = 7'd22;
                kind_d   = DK_OCT;
                pfx_ch_d = CH_LO;
              end
              TYPE_B: begin
                dig_d    = {value_i, 16'b0};
                ndig_d   = 7'd64;
                kind_d   = DK_BIN;
                pfx_ch_d = CH_LB;
              end
              default: begin
                dig_d    = {value_i, 16'b0};
                ndig_d   = 7'd16;
                kind_d   = DK_HEX;
                pfx_ch_d = (type_eff == TYPE_XU) ? CH_UX : CH_LX;
              end
            endcase
          end
        end
      end
      ST_CONV: begin
        dig_d  = {bcd_adj[DIG_W-2:0], val_q[63]};
        val_d  = {val_q[62:0], 1'b0};
        step_d = step_q + 6'd1;
      end
      ST_NORM: begin
        if ((ndig_q > 7'd1) && (top_dig == 4'd0)) begin
          ndig_d = ndig_q - 7'd1;
          case (kind_q)
            DK_BIN:  dig_d = {dig_q[DIG_W-2:0], 1'b0};
            DK_OCT:  dig_d = {dig_q[DIG_W-4:0], 3'b0};
            default: dig_d = {dig_q[DIG_W-5:0], 4'b0};
          endcase
        end
      end
      ST_SETUP: begin
        fill_d  = fill_c;
        lpad_d  = lpad_c;
        mpad_d  = mpad_c;
        rpad_d  = rpad_c;
        total_d = total_c;
        ocnt_d  = 7'd0;
      end
      ST_LPAD: begin
        if (emit) lpad_d = lpad_q - 7'd1;
      end
      ST_MPAD: begin
        if (emit) mpad_d = mpad_q - 7'd1;
      end
      ST_RPAD: begin
        if (emit) rpad_d = rpad_q - 7'd1;
      end
      ST_DIG: begin
        ndig_d = ndig_q - 7'd1;
        case (kind_q)
          DK_BIN:  dig_d = {dig_q[DIG_W-2:0], 1'b0};
          DK_OCT:  dig_d = {dig_q[DIG_W-4:0], 3'b0};
          default: dig_d = {dig_q[DIG_W-5:0], 4'b0};
        endcase
      end
      default: begin
        ndig_d = ndig_q;
      end
    endcase

    if (emit) ocnt_d = ocnt_q + 7'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      strobe_q    <= 1'b0;
      fill_char_q <= CH_SPACE;
      align_q     <= AL_NONE;
      sign_mode_q <= SG_MINUS;
      alt_q       <= 1'b0;
      zero_pad_q  <= 1'b0;
      min_width_q <= 7'd0;
      type_q      <= TYPE_N;
      limit_q     <= 7'd64;
    end else begin
      state_q  <= state_d;
      strobe_q <= strobe_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_FILL:  fill_char_q <= cfg_data_i;
          REG_ALIGN: align_q     <= cfg_data_i[2:0];
          REG_SIGN:  sign_mode_q <= cfg_data_i[1:0];
          REG_ALT:   alt_q       <= cfg_data_i[0];
          REG_ZERO:  zero_pad_q  <= cfg_data_i[0];
          REG_WIDTH: min_width_q <= cfg_data_i[6:0];
          REG_TYPE:  type_q      <= cfg_data_i[2:0];
          REG_LIMIT: limit_q     <= cfg_data_i[6:0];
          default:   limit_q     <= limit_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q     <= val_d;
    dig_q     <= dig_d;
    step_q    <= step_d;
    ndig_q    <= ndig_d;
    kind_q    <= kind_d;
    sign_q    <= sign_d;
    sign_ch_q <= sign_ch_d;
    pfx_q     <= pfx_d;
    pfx_ch_q  <= pfx_ch_d;
    upper_q   <= upper_d;
    fill_q    <= fill_d;
    lpad_q    <= lpad_d;
    mpad_q    <= mpad_d;
    rpad_q    <= rpad_d;
    total_q   <= total_d;
    ocnt_q    <= ocnt_d;
    last_q    <= last_d;
    char_q    <= char_d;
  end

  assign busy_o       = (state_q != ST_IDLE);
  assign out_strobe_o = strobe_q;
  assign out_char_o   = char_q;
  assign last_char_o  = last_q;

endmodule

// ----- sim/tb_integer_format_spec_formatter.sv -----
// ----------------------------------------------------------------------------
// tb_integer_format_spec_formatter
// Self-checking bench for the integer format-spec formatter: walks the format
// spec through sign, radix, padding and output-limit settings, then random
// specs and values, and checks each emitted character against a local model.
// ----------------------------------------------------------------------------
module tb_integer_format_spec_formatter;
  import ifsf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DrainCycles = 200;
  localparam int unsigned CycleLimit  = 300000;

  typedef logic [7:0] char_q_t [$];

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } exp_char_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [7:0]  cfg_data_i = '0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [63:0] value_i = '0;
  logic        out_strobe_o;
  logic [7:0]  out_char_o;
  logic        last_char_o;

  // Spec as the block should hold it
  logic [7:0] spec_fill  = CH_SPACE;
  logic [2:0] spec_align = AL_NONE;
  logic [1:0] spec_sign  = SG_MINUS;
  logic       spec_alt   = 1'b0;
  logic       spec_zero  = 1'b0;
  logic [6:0] spec_width = 7'd0;
  logic [2:0] spec_type  = TYPE_N;
  logic [6:0] spec_limit = 7'd64;

  exp_char_t   expected_chars [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  bit          sender_burst = 1'b0;

  integer_format_spec_formatter i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .value_i     (value_i),
    .out_strobe_o(out_strobe_o),
    .out_char_o  (out_char_o),
    .last_char_o (last_char_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Text the block should emit for one value under the current spec
  function automatic char_q_t format_value(input logic [63:0] v);
    char_q_t     body;
    char_q_t     digits;
    char_q_t     line;
    logic [63:0] mag;
    logic [63:0] base;
    logic [3:0]  dig;
    logic [2:0]  tm;
    logic [2:0]  al;
    logic [7:0]  fill;
    bit          upper;
    bit          sign_first;
    int unsigned pad;
    int unsigned lpad;
    int unsigned cap;
    tm = (spec_type > TYPE_N) ? TYPE_N : spec_type;
    al = (spec_align > AL_SIGNED) ? AL_NONE : spec_align;
    if (tm == TYPE_D || tm == TYPE_N) begin
      mag = v[63] ? (~v + 64'd1) : v;
      do begin
        digits.push_front(CH_ZERO + 8'(mag % 64'd10));
        mag = mag / 64'd10;
      end while (mag != 0);
      if (v[63]) begin
        body.push_back(CH_MINUS);
      end else if (tm == TYPE_D && spec_sign == SG_PLUS) begin
        body.push_back(CH_PLUS);
      end else if (tm == TYPE_D && spec_sign == SG_SPACE) begin
        body.push_back(CH_SPACE);
      end
    end else begin
      base  = (tm == TYPE_O) ? 64'd8 : (tm == TYPE_B) ? 64'd2 : 64'd16;
      upper = (tm == TYPE_XU);
      if (spec_alt) begin
        body.push_back(CH_ZERO);
        body.push_back((tm == TYPE_X) ? CH_LX : (tm == TYPE_XU) ? CH_UX :
                       (tm == TYPE_O) ? CH_LO : CH_LB);
      end
      mag = v;
      do begin
        dig = 4'(mag % base);
        digits.push_front((dig < 4'd10) ? CH_ZERO + 8'(dig) :
                          (upper ? CH_UA : CH_LA) + 8'(dig) - 8'd10);
        mag = mag / base;
      end while (mag != 0);
    end
    foreach (digits[i]) body.push_back(digits[i]);

    if (spec_width == 0 || body.size() >= spec_width) begin
      line = body;
    end else begin
      pad  = spec_width - body.size();
      fill = (spec_zero && al == AL_NONE) ? CH_ZERO : spec_fill;
      if (al == AL_NONE) al = spec_zero ? AL_RIGHT : AL_LEFT;
      sign_first = body[0] inside {CH_PLUS, CH_MINUS, CH_SPACE};
      if ((al == AL_RIGHT && fill == CH_ZERO && sign_first) ||
          (al == AL_SIGNED && sign_first)) begin
        line.push_back(body[0]);
        repeat (pad) line.push_back(fill);
        for (int i = 1; i < body.size(); i++) line.push_back(body[i]);
      end else if (al == AL_LEFT) begin
        line = body;
        repeat (pad) line.push_back(fill);
      end else begin
        // right, centre, and sign-aware with no sign to lead
        lpad = (al == AL_CENTRE) ? pad / 2 : pad;
        repeat (lpad) line.push_back(fill);
        foreach (body[i]) line.push_back(body[i]);
        repeat (pad - lpad) line.push_back(fill);
      end
    end

    cap = (spec_limit > MAX_CHARS_DEF) ? MAX_CHARS_DEF : spec_limit;
    while (line.size() > cap) void'(line.pop_back());
    return line;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // Start is lowered in the step that ends the last request
  task automatic wait_idle();
    start_i <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk_i);
    // a request with an output limit of zero may still be running
    repeat (DrainCycles) @(posedge clk_i);
    while (busy_o !== 1'b0) @(posedge clk_i);
  endtask

  task automatic set_spec(input logic [7:0] fill, input logic [2:0] align,
                          input logic [1:0] sign, input logic alt,
                          input logic zero, input logic [6:0] width,
                          input logic [2:0] tmode, input logic [6:0] limit,
                          input bit junk);
    logic [7:0] data [8];
    logic [7:0] mask [8];
    wait_idle();
    data[REG_FILL]  = fill;          mask[REG_FILL]  = 8'hff;
    data[REG_ALIGN] = 8'(align);     mask[REG_ALIGN] = 8'h07;
    data[REG_SIGN]  = 8'(sign);      mask[REG_SIGN]  = 8'h03;
    data[REG_ALT]   = 8'(alt);       mask[REG_ALT]   = 8'h01;
    data[REG_ZERO]  = 8'(zero);      mask[REG_ZERO]  = 8'h01;
    data[REG_WIDTH] = 8'(width);     mask[REG_WIDTH] = 8'h7f;
    data[REG_TYPE]  = 8'(tmode);     mask[REG_TYPE]  = 8'h07;
    data[REG_LIMIT] = 8'(limit);     mask[REG_LIMIT] = 8'h7f;
    for (int i = 0; i < 8; i++) begin
      // unused upper data bits must be ignored
      if (junk) data[i] = data[i] | (8'($urandom()) & ~mask[i]);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= 3'(i);
      cfg_data_i <= data[i];
      @(posedge clk_i);
    end
    cfg_we_i   <= 1'b0;
    spec_fill  = data[REG_FILL];
    spec_align = data[REG_ALIGN][2:0];
    spec_sign  = data[REG_SIGN][1:0];
    spec_alt   = data[REG_ALT][0];
    spec_zero  = data[REG_ZERO][0];
    spec_width = data[REG_WIDTH][6:0];
    spec_type  = data[REG_TYPE][2:0];
    spec_limit = data[REG_LIMIT][6:0];
    sender_burst = ($urandom_range(0, 3) == 0);
  endtask

  task automatic send_value(input logic [63:0] v);
    char_q_t     text;
    int unsigned gap;
    gap = sender_burst ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    value_i <= v;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    text = format_value(v);
    foreach (text[i]) expected_chars.push_back('{ch: text[i], last: i == text.size() - 1});
  endtask

  function automatic logic [63:0] random_value();
    logic [63:0] v;
    v = {$urandom(), $urandom()};
    case ($urandom_range(0, 5))
      0: v = 64'($urandom_range(0, 1000));
      1: v = -64'($urandom_range(1, 1000));
      2: v = v >> $urandom_range(0, 63);
      3: v = -(v >> $urandom_range(0, 63));
      4: begin
        case ($urandom_range(0, 3))
          0: v = 64'h8000_0000_0000_0000;
          1: v = 64'h7fff_ffff_ffff_ffff;
          2: v = '0;
          default: v = '1;
        endcase
      end
      default: ;
    endcase
    return v;
  endfunction

  task automatic test_reset_defaults();
    send_value(64'd0);
    send_value(64'h8000_0000_0000_0000);
  endtask

  task automatic test_decimal_signs();
    set_spec(CH_SPACE, AL_NONE, SG_PLUS, 1'b0, 1'b0, 7'd0, TYPE_D, 7'd64, 1'b0);
    send_value(64'd5);
    send_value(64'h8000_0000_0000_0000);
    set_spec(CH_SPACE, AL_NONE, SG_SPACE, 1'b0, 1'b0, 7'd0, TYPE_D, 7'd64, 1'b0);
    send_value(64'd7);
    // unused sign code behaves as minus only
    set_spec(CH_SPACE, AL_NONE, 2'd3, 1'b0, 1'b0, 7'd0, TYPE_D, 7'd64, 1'b0);
    send_value(64'd9);
    // plain decimal ignores the sign mode
    set_spec(CH_SPACE, AL_NONE, SG_PLUS, 1'b0, 1'b0, 7'd0, TYPE_N, 7'd64, 1'b0);
    send_value(64'd3);
  endtask

  task automatic test_radix_modes();
    set_spec(CH_SPACE, AL_NONE, SG_PLUS, 1'b1, 1'b0, 7'd0, TYPE_X, 7'd64, 1'b0);
    send_value('1);
    set_spec(CH_SPACE, AL_NONE, SG_SPACE, 1'b1, 1'b0, 7'd0, TYPE_XU, 7'd64, 1'b0);
    send_value(64'h0000_0000_00ab_cdef);
    set_spec(CH_SPACE, AL_NONE, SG_MINUS, 1'b1, 1'b0, 7'd0, TYPE_O, 7'd64, 1'b0);
    send_value(64'd8);
    // prefix plus 64 bits runs past the output limit
    set_spec(CH_SPACE, AL_NONE, SG_MINUS, 1'b1, 1'b0, 7'd0, TYPE_B, 7'd64, 1'b0);
    send_value(64'h8000_0000_0000_0000);
    set_spec(CH_SPACE, AL_NONE, SG_MINUS, 1'b0, 1'b0, 7'd0, TYPE_B, 7'd64, 1'b0);
    send_value(64'd0);
    // unused type codes fall back to plain decimal
    set_spec(CH_SPACE, AL_NONE, SG_PLUS, 1'b1, 1'b0, 7'd0, 3'd6, 7'd64, 1'b0);
    send_value(-64'sd12);
    set_spec(CH_SPACE, AL_NONE, SG_PLUS, 1'b1, 1'b0, 7'd0, 3'd7, 7'd64, 1'b0);
    send_value(64'd12);
  endtask

  task automatic test_padding();
    set_spec(8'h2a, AL_SIGNED, SG_MINUS, 1'b0, 1'b0, 7'd10, TYPE_D, 7'd64, 1'b0);
    send_value(-64'sd3);
    // sign-aware with no sign pads on the left
    set_spec(8'h2a, AL_SIGNED, SG_MINUS, 1'b0, 1'b0, 7'd5, TYPE_N, 7'd64, 1'b0);
    send_value(64'd77);
    set_spec(8'h2e, AL_CENTRE, SG_MINUS, 1'b0, 1'b0, 7'd9, TYPE_D, 7'd64, 1'b0);
    send_value(64'd42);
    set_spec(8'h2e, AL_NONE, SG_PLUS, 1'b0, 1'b1, 7'd8, TYPE_D, 7'd64, 1'b0);
    send_value(64'd17);
    // zero fill goes ahead of the prefix, which is no sign
    set_spec(CH_ZERO, AL_RIGHT, SG_MINUS, 1'b1, 1'b0, 7'd12, TYPE_X, 7'd64, 1'b0);
    send_value(64'd255);
    set_spec(8'h23, 3'd5, SG_MINUS, 1'b0, 1'b1, 7'd6, TYPE_D, 7'd64, 1'b0);
    send_value('1);
    set_spec(8'hff, AL_LEFT, SG_MINUS, 1'b0, 1'b0, 7'd64, TYPE_D, 7'd64, 1'b0);
    send_value('1);
    set_spec(8'h5f, AL_RIGHT, SG_SPACE, 1'b0, 1'b0, 7'd127, TYPE_D, 7'd64, 1'b0);
    send_value(64'd1);
  endtask

  task automatic test_out_limit();
    set_spec(CH_SPACE, AL_NONE, SG_MINUS, 1'b0, 1'b0, 7'd0, TYPE_D, 7'd0, 1'b0);
    send_value(64'd123);
    set_spec(CH_SPACE, AL_NONE, SG_MINUS, 1'b0, 1'b0, 7'd0, TYPE_D, 7'd1, 1'b0);
    send_value(-64'sd45);
    set_spec(8'h00, AL_CENTRE, SG_MINUS, 1'b0, 1'b0, 7'd100, TYPE_D, 7'd127, 1'b0);
    send_value(64'd6);
  endtask

  task automatic test_random_specs();
    logic [6:0] width;
    logic [6:0] limit;
    for (int phase = 0; phase < 8; phase++) begin
      width = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127)) :
                                            7'($urandom_range(0, 24));
      limit = ($urandom_range(0, 5) == 0) ? 7'($urandom_range(0, 127)) : 7'd64;
      set_spec(8'($urandom()), 3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
               1'($urandom()), 1'($urandom()), width, 3'($urandom_range(0, 7)), limit,
               1'b1);
      repeat ($urandom_range(6, 14)) send_value(random_value());
    end
  endtask

  // One result per strobe, checked against the oldest expected character
  always @(posedge clk_i) begin
    exp_char_t want;
    if (rst_ni && out_strobe_o === 1'b1) begin
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected char 0x%02h last=%b", out_char_o, last_char_o));
      end else begin
        want = expected_chars.pop_front();
        if (out_char_o !== want.ch) begin
          report_mismatch($sformatf("out_char 0x%02h, want 0x%02h", out_char_o, want.ch));
        end
        if (last_char_o !== want.last) begin
          report_mismatch($sformatf("last_char %b, want %b", last_char_o, want.last));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_decimal_signs();
    test_radix_modes();
    test_padding();
    test_out_limit();
    test_random_specs();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/ifsf_pkg.sv
src/integer_format_spec_formatter.sv
sim/tb_integer_format_spec_formatter.sv
